// ===== hw/rtl/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the haptic pattern sequencer
// Sizes of the pattern ring and step memory, operation and status codes,
// and the control bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int PATTERN_SLOTS = 8;
    localparam int MAX_STEPS     = 32;
    localparam int MEM_DEPTH     = PATTERN_SLOTS * MAX_STEPS;

    localparam int SLOT_W = $clog2(PATTERN_SLOTS);
    localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int FILL_W = $clog2(PATTERN_SLOTS + 1);
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int DUR_W  = 16;
    localparam int QCNT_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_DND = PADDR_W'(0);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_COMMIT = 2'd1,
        OP_STOP   = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(PATTERN_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

// ===== hw/rtl/hps_ctrl.sv =====
// ----------------------------------------------------------------------------
// hps_ctrl: item sequencing for the haptic pattern sequencer
// Takes one item, then runs its execute cycle once the output slot is free.
// ----------------------------------------------------------------------------
module hps_ctrl
    import hps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   w_slot_free;

    assign w_slot_free   = !i_status.out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = o_in_ready && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC) && w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // hold until the result has somewhere to go
                    if (w_slot_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/hps_datapath.sv =====
// ----------------------------------------------------------------------------
// hps_datapath: pattern state, step memory and result register
// Holds the staged and queued patterns, plays the head pattern on ticks and
// forms one result per item. Also holds the do-not-disturb register.
// ----------------------------------------------------------------------------
module hps_datapath
    import hps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    input  logic [1:0]            i_op,
    input  logic [DUR_W-1:0]      i_dur,
    input  logic                  i_repeat,
    input  logic                  i_stop,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_dnd,
    output logic                  o_dnd
);

    // captured item
    t_op              r_op;
    logic [DUR_W-1:0] r_dur;
    logic             r_repeat;
    logic             r_stop;

    // pattern state
    logic [DUR_W-1:0]  r_mem [MEM_DEPTH];
    logic [DUR_W-1:0]  r_rd_data;
    logic [CNT_W-1:0]  r_slot_cnt [PATTERN_SLOTS];
    logic              r_slot_rep [PATTERN_SLOTS];
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DUR_W-1:0]  r_elapsed, n_elapsed;
    logic              r_playing, n_playing;
    logic [CNT_W-1:0]  r_staged, n_staged;
    logic              r_dnd;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr;
    logic              w_mem_we, w_slot_we;
    logic              w_drop, w_start;
    logic [DUR_W:0]    w_el;
    logic [CNT_W:0]    w_step_nx;
    t_status           w_status;
    logic [FILL_W-1:0] w_waiting;

    assign w_rd_addr = ADDR_W'(r_head) * ADDR_W'(MAX_STEPS) + ADDR_W'(r_step);
    assign w_wr_addr = ADDR_W'(r_tail) * ADDR_W'(MAX_STEPS) + ADDR_W'(r_staged);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_step    = r_step;
        n_elapsed = r_elapsed;
        n_playing = r_playing;
        n_staged  = r_staged;
        w_mem_we  = 1'b0;
        w_slot_we = 1'b0;
        w_drop    = 1'b0;
        w_start   = 1'b0;
        w_status  = ST_OK;
        w_el      = '0;
        w_step_nx = '0;

        case (r_op)
            OP_APPEND: begin
                if (r_fill >= FILL_W'(PATTERN_SLOTS)) begin
                    w_status = ST_FULL;
                end else if (r_staged >= CNT_W'(MAX_STEPS)) begin
                    w_status = ST_TRUNCATED;
                end else begin
                    w_mem_we = 1'b1;
                    n_staged = r_staged + CNT_W'(1);
                end
            end
            OP_COMMIT: begin
                if (r_staged == '0) begin
                    w_status = ST_EMPTY;
                end else if (r_fill >= FILL_W'(PATTERN_SLOTS)) begin
                    w_status = ST_FULL;
                end else begin
                    w_slot_we = 1'b1;
                    n_tail    = next_slot(r_tail);
                    n_fill    = r_fill + FILL_W'(1);
                    n_staged  = '0;
                    w_drop    = r_stop;
                    w_start   = !r_stop;
                end
            end
            OP_STOP: begin
                w_drop = 1'b1;
            end
            default: begin
                if (r_playing) begin
                    w_el      = {1'b0, r_elapsed} + (DUR_W+1)'(1);
                    n_elapsed = w_el[DUR_W-1:0];
                    if (w_el >= {1'b0, r_rd_data}) begin
                        n_elapsed = '0;
                        w_step_nx = (CNT_W+1)'(r_step) + (CNT_W+1)'(1);
                        n_step    = w_step_nx[STEP_W-1:0];
                        if (w_step_nx >= {1'b0, r_slot_cnt[r_head]}) begin
                            n_step = '0;
                            w_drop = !r_slot_rep[r_head];
                        end
                    end
                end
            end
        endcase

        // abort the playing pattern and retire its slot
        if (w_drop && n_playing) begin
            n_playing = 1'b0;
            n_step    = '0;
            n_elapsed = '0;
            n_head    = next_slot(n_head);
            n_fill    = n_fill - FILL_W'(1);
        end
        // start the head pattern when nothing plays
        if ((w_drop || w_start) && !n_playing && (n_fill != '0)) begin
            n_playing = 1'b1;
            n_step    = '0;
            n_elapsed = '0;
        end

        w_waiting  = n_fill - FILL_W'(n_playing);
        n_out_data = {QCNT_W'(w_waiting), w_status, n_playing,
                      n_playing && !n_step[0] && !r_dnd};
    end

    // capture the item on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_op);
            r_dur    <= i_dur;
            r_repeat <= i_repeat;
            r_stop   <= i_stop;
        end
    end

    // step memory: read every cycle; the value latched at accept serves the tick
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        if (i_cmd.exec && w_mem_we) r_mem[w_wr_addr] <= r_dur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_step    <= '0;
            r_elapsed <= '0;
            r_playing <= 1'b0;
            r_staged  <= '0;
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                r_slot_cnt[i] <= '0;
                r_slot_rep[i] <= 1'b0;
            end
        end else if (i_cmd.exec) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_step    <= n_step;
            r_elapsed <= n_elapsed;
            r_playing <= n_playing;
            r_staged  <= n_staged;
            if (w_slot_we) begin
                r_slot_cnt[r_tail] <= r_staged;
                r_slot_rep[r_tail] <= r_repeat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dnd <= 1'b0;
        end else if (i_cfg_we) begin
            r_dnd <= i_cfg_dnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_out_data <= n_out_data;
    end

    assign o_status.out_valid = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;
    assign o_dnd              = r_dnd;

endmodule

// ===== hw/rtl/haptic_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Each item is accepted in the idle state and then executed in the execute
// state, which loads the result register; the result is valid after the execute edge.
// Only one item is in flight: the controller takes no new item until the last one has
// executed. A stalled result holds the next item in its execute
// cycle and blocks further accepts. Reset is synchronous, active low; the step
// memory is not cleared and all control state is ready at once.
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer: vibration-motor pattern player
// Stages step patterns, queues them in a ring of slots and plays the head
// pattern on millisecond tick items.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer
    import hps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] step_duration, [16] repeat_forever, [17] stop_playing, [23:18] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] motor_drive, [1] busy_res, [3:2] status, [7:4] queued_patterns
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_cfg_we;
    logic       w_dnd;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr == ADDR_DND);
    assign prdata   = (paddr == ADDR_DND) ? PDATA_W'(w_dnd) : '0;

    hps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    hps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_op        (s_axis_tuser),
        .i_dur       (s_axis_tdata[DUR_W-1:0]),
        .i_repeat    (s_axis_tdata[DUR_W]),
        .i_stop      (s_axis_tdata[DUR_W+1]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_dnd   (pwdata[0]),
        .o_dnd       (w_dnd)
    );

    // one item in flight: an accept is followed by the execute cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    // the motor runs only while a pattern plays
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
        else $error("motor drive without a playing pattern");

    // no result is pending after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

// ===== sim/haptic_pattern_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer_tb: self-checking bench for the pattern sequencer
// Streams append, commit, stop and tick items into the block under random
// idling on both sides and predicts every result from its own model of the
// pattern ring. Results are checked field by field in order. The
// do-not-disturb register is toggled between phases while the block is idle.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer_tb;
    import hps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 425;

    typedef struct {
        t_op              op;
        logic [DUR_W-1:0] dur;
        logic             rep;
        logic             stopc;
    } t_seq_cmd;

    // same bit order as m_axis_tdata
    typedef struct packed {
        logic [QCNT_W-1:0] queued;
        t_status           status;
        logic              busy;
        logic              motor;
    } t_seq_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [15:0] step_duration, [16] repeat_forever, [17] stop_playing, [23:18] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] operation
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] motor_drive, [1] busy_res, [3:2] status, [7:4] queued_patterns
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    haptic_pattern_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pattern ring model
    // ------------------------------------------------------------------
    logic [DUR_W-1:0]  step_mem [MEM_DEPTH];
    logic [CNT_W-1:0]  slot_len [PATTERN_SLOTS];
    logic              slot_loop [PATTERN_SLOTS];
    logic [SLOT_W-1:0] ring_head;
    logic [SLOT_W-1:0] ring_tail;
    logic [FILL_W-1:0] ring_fill;
    logic [CNT_W-1:0]  play_step;
    logic [CNT_W-1:0]  staged_len;
    logic [DUR_W-1:0]  play_ms;
    logic              play_on;
    logic              dnd_on;

    t_seq_cmd    pending_cmds[$];
    t_seq_result expected_results[$];
    int          gen_count = 0;
    int          failures = 0;
    int          cycle_count = 0;
    int          rx_index = 0;

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        return SLOT_W'((int'(s) + 1) % PATTERN_SLOTS);
    endfunction

    function automatic void start_next();
        if (!play_on && ring_fill != 0) begin
            play_on   = 1'b1;
            play_step = '0;
            play_ms   = '0;
        end
    endfunction

    // drop the playing pattern, then let the next one in the ring start
    function automatic void abort_playing();
        if (play_on) begin
            play_on   = 1'b0;
            play_step = '0;
            play_ms   = '0;
            ring_head = slot_after(ring_head);
            ring_fill = ring_fill - 1'b1;
        end
        start_next();
    endfunction

    function automatic void advance_ms();
        int idx;
        if (!play_on) return;
        idx = int'(ring_head) * MAX_STEPS + int'(play_step) % MAX_STEPS;
        play_ms = play_ms + 1'b1;
        // a zero-length step still lasts one tick
        if (play_ms >= step_mem[idx]) begin
            play_ms   = '0;
            play_step = play_step + 1'b1;
            if (play_step >= slot_len[ring_head]) begin
                play_step = '0;
                if (!slot_loop[ring_head]) abort_playing();
            end
        end
    endfunction

    function automatic t_seq_result sequencer_apply(input t_seq_cmd c);
        t_seq_result r;
        t_status     st;
        int          slot;
        st   = ST_OK;
        slot = int'(ring_tail);
        case (c.op)
            OP_APPEND: begin
                if (ring_fill >= PATTERN_SLOTS) begin
                    st = ST_FULL;
                end else if (staged_len >= MAX_STEPS) begin
                    st = ST_TRUNCATED;
                end else begin
                    step_mem[slot * MAX_STEPS + int'(staged_len)] = c.dur;
                    staged_len = staged_len + 1'b1;
                end
            end
            OP_COMMIT: begin
                if (staged_len == 0) begin
                    st = ST_EMPTY;
                end else if (ring_fill >= PATTERN_SLOTS) begin
                    st = ST_FULL;
                end else begin
                    slot_len[slot]  = staged_len;
                    slot_loop[slot] = c.rep;
                    ring_tail       = slot_after(ring_tail);
                    ring_fill       = ring_fill + 1'b1;
                    staged_len      = '0;
                    if (c.stopc) abort_playing();
                    else start_next();
                end
            end
            OP_STOP: begin
                abort_playing();
            end
            default: begin
                advance_ms();
            end
        endcase
        r.motor  = play_on && !play_step[0] && !dnd_on;
        r.busy   = play_on;
        r.status = st;
        r.queued = QCNT_W'(ring_fill - play_on);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic void queue_cmd(input t_op op, input logic [DUR_W-1:0] dur,
                                      input logic rep, input logic stopc);
        t_seq_cmd c;
        c.op    = op;
        c.dur   = dur;
        c.rep   = rep;
        c.stopc = stopc;
        pending_cmds.push_back(c);
        gen_count++;
    endfunction

    // mostly short steps so patterns run to their end; long ones get stopped
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return DUR_W'($urandom);
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return DUR_W'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic void random_episode();
        int kind;
        int steps;
        kind = $urandom_range(0, 19);
        if (kind < 11) begin
            // a staged pattern, its commit, then time it
            steps = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
            repeat (steps) queue_cmd(OP_APPEND, pick_duration(),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            queue_cmd(OP_COMMIT, DUR_W'($urandom), $urandom_range(0, 4) == 0,
                      $urandom_range(0, 5) == 0);
            repeat ($urandom_range(0, 24)) queue_cmd(OP_TICK, DUR_W'($urandom),
                                                     1'($urandom_range(0, 1)),
                                                     1'($urandom_range(0, 1)));
        end else if (kind < 15) begin
            queue_cmd(OP_STOP, DUR_W'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 8)) queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
        end else if (kind < 17) begin
            // push toward a full ring
            repeat ($urandom_range(3, 9)) begin
                queue_cmd(OP_APPEND, DUR_W'($urandom_range(0, 2)), 1'b0, 1'b0);
                queue_cmd(OP_COMMIT, '0, $urandom_range(0, 4) == 0, 1'b0);
            end
        end else begin
            repeat ($urandom_range(1, 6)) queue_cmd(t_op'($urandom_range(0, 3)),
                                                    DUR_W'($urandom),
                                                    1'($urandom_range(0, 1)),
                                                    1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic void directed_items();
        queue_cmd(OP_TICK, '0, 1'b0, 1'b0);          // tick while idle
        queue_cmd(OP_STOP, '1, 1'b1, 1'b1);          // stop while idle
        queue_cmd(OP_COMMIT, '0, 1'b1, 1'b1);        // empty commit refused
        queue_cmd(OP_APPEND, '0, 1'b1, 1'b1);        // zero-length step
        queue_cmd(OP_APPEND, '1, 1'b0, 1'b0);
        queue_cmd(OP_COMMIT, '1, 1'b0, 1'b0);        // starts at once
        queue_cmd(OP_TICK, '1, 1'b1, 1'b1);          // zero step ends after one tick
        queue_cmd(OP_APPEND, DUR_W'(1), 1'b0, 1'b0);
        queue_cmd(OP_COMMIT, '0, 1'b1, 1'b1);        // queue, then abort the long step
        queue_cmd(OP_TICK, '0, 1'b0, 1'b0);          // single-step loop wraps
        queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
        // fill every slot behind the looping pattern, then one append too many
        repeat (PATTERN_SLOTS - 1) begin
            queue_cmd(OP_APPEND, DUR_W'(2), 1'b0, 1'b0);
            queue_cmd(OP_COMMIT, '0, 1'b0, 1'b0);
        end
        queue_cmd(OP_APPEND, DUR_W'(3), 1'b0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    t_seq_cmd tx_cmd;
    logic     tx_loaded = 1'b0;
    logic     tx_steady = 1'b0;
    int       tx_hold = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_loaded = 1'b0;
            tx_hold   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(sequencer_apply(tx_cmd));
                tx_loaded = 1'b0;
            end
            if (!tx_loaded) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    tx_cmd    = pending_cmds.pop_front();
                    tx_loaded = 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({tx_cmd.stopc, tx_cmd.rep, tx_cmd.dur});
                    s_axis_tuser  <= tx_cmd.op;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
                    tx_hold = tx_steady ? 0 : $urandom_range(0, 19);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    t_seq_result rx_got;
    t_seq_result rx_want;
    logic        rx_steady = 1'b0;
    int          rx_hold = 0;

    function automatic void log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("[cycle %0d] %s", cycle_count, msg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_got = m_axis_tdata;
                if (expected_results.size() == 0) begin
                    log_failure($sformatf("result %0d with nothing expected: 0x%02h",
                                          rx_index, m_axis_tdata));
                end else begin
                    rx_want = expected_results.pop_front();
                    if (rx_got.motor !== rx_want.motor)
                        log_failure($sformatf("result %0d motor_drive: expected %0d got %0d",
                                              rx_index, rx_want.motor, rx_got.motor));
                    if (rx_got.busy !== rx_want.busy)
                        log_failure($sformatf("result %0d busy_res: expected %0d got %0d",
                                              rx_index, rx_want.busy, rx_got.busy));
                    if (rx_got.status !== rx_want.status)
                        log_failure($sformatf("result %0d status: expected %0d got %0d",
                                              rx_index, rx_want.status, rx_got.status));
                    if (rx_got.queued !== rx_want.queued)
                        log_failure($sformatf("result %0d queued_patterns: expected %0d got %0d",
                                              rx_index, rx_want.queued, rx_got.queued));
                end
                rx_index++;
                if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
                rx_hold = rx_steady ? 0 : $urandom_range(0, 19);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_axis_tready <= (rx_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || tx_loaded || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_dnd(input logic value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DND;
        // upper bits are don't-care for a one-bit register
        pwdata  <= (PDATA_W'($urandom) & ~PDATA_W'(1)) | PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dnd_on = value;
    endtask

    initial begin
        int gen_target;
        ring_head  = '0;
        ring_tail  = '0;
        ring_fill  = '0;
        play_step  = '0;
        staged_len = '0;
        play_ms    = '0;
        play_on    = 1'b0;
        dnd_on     = 1'b0;
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
            slot_len[s]  = '0;
            slot_loop[s] = 1'b0;
        end
        gen_target = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_dnd(ph[0]);
            if (ph == 0) directed_items();
            gen_target += PHASE_ITEMS;
            while (gen_count < gen_target) random_episode();
        end
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hps_pkg.sv
hw/rtl/hps_ctrl.sv
hw/rtl/hps_datapath.sv
hw/rtl/haptic_pattern_sequencer.sv
sim/haptic_pattern_sequencer_tb.sv
